// ===== hdl/kssh_pkg.sv =====
package kssh_pkg;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_BETA   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_BW = 1'b1;

  localparam logic [CFG_W-1:0] BETA_RESET   = 32'h0000_0000;
  localparam logic [CFG_W-1:0] INV_BW_RESET = 32'h0001_0000;

  localparam int MAX_ITEMS = 1048576;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  localparam int KERNEL_TABLE_SIZE = 1024;
  localparam int TAB_AW            = $clog2(KERNEL_TABLE_SIZE);
  localparam int KERN_W            = 16;
  localparam int U_RANGE_LOG       = 19;
  localparam int U_Q_W             = U_RANGE_LOG + 16;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int M_W    = 42;
  localparam int M_HI_W = M_W - 32;
  localparam int ACC_W  = M_W + 32;
  localparam int S_W    = 49;
  localparam int SUM_W  = 64;
  localparam int DIVD_W = SUM_W - 1;
  localparam int DIV_CNT_W = $clog2(DIVD_W);

  localparam int K_W = 3;
  localparam logic [K_W-1:0] K_U_PRODUCT = 3'd0;
  localparam logic [K_W-1:0] K_FIRST_X2  = 3'd3;
  localparam logic [K_W-1:0] MUL_STEPS   = 3'd4;

  localparam logic [31:0] OUT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] OUT_MIN = 32'h8000_0000;

  localparam longint unsigned ONE_Q30          = 64'd1073741824;
  localparam longint unsigned INV_SQRT_2PI_Q30 = 64'd428361012;
  localparam longint unsigned U_RANGE_Q16      = 64'd524288;
  localparam int              SERIES_TERMS     = 20;

  typedef struct packed {
    logic        outcome;
    logic [31:0] first_regressor;
    logic [31:0] second_regressor;
    logic        last_item;
  } in_item_t;

  typedef struct packed {
    logic [31:0] mean_value;
    logic        saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BETA,
    S_SUM,
    S_MLO,
    S_MHI,
    S_MADD,
    S_TAB,
    S_SAT,
    S_ACC,
    S_DSTART,
    S_DRUN,
    S_DOUT
  } state_e;

  typedef logic [KERN_W-1:0] kern_tab_t [KERNEL_TABLE_SIZE];

  function automatic longint unsigned exp_neg_q30(longint unsigned f);
    longint unsigned term;
    longint          sum;
    term = ONE_Q30;
    sum  = longint'(ONE_Q30);
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      term = ((term * f) >> 30) / 64'(k);
      if ((k % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return (sum < 0) ? 64'd0 : $unsigned(sum);
  endfunction

  function automatic kern_tab_t build_kern_tab();
    kern_tab_t       tab;
    longint unsigned e1;
    longint unsigned u;
    longint unsigned x;
    longint unsigned n;
    longint unsigned r;
    longint unsigned g;
    e1 = exp_neg_q30(ONE_Q30);
    for (int i = 0; i < KERNEL_TABLE_SIZE; i++) begin
      u = (64'(i) * U_RANGE_Q16) / KERNEL_TABLE_SIZE;
      x = (u * u) >> 3;
      n = x >> 30;
      r = exp_neg_q30(x & (ONE_Q30 - 64'd1));
      for (longint unsigned j = 0; j < n; j++) begin
        r = (r * e1) >> 30;
      end
      g = (((u * r) >> 30) * INV_SQRT_2PI_Q30) >> 30;
      tab[i] = KERN_W'(g);
    end
    return tab;
  endfunction

endpackage

// ===== hdl/kssh_mul.sv =====
module kssh_mul (
  input  logic                                 clk_i,
  input  logic signed [kssh_pkg::MUL_W-1:0]    a_i,
  input  logic signed [kssh_pkg::MUL_W-1:0]    b_i,
  output logic signed [kssh_pkg::PROD_W-1:0]   p_o
);
  import kssh_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== hdl/kssh_div.sv =====
module kssh_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [kssh_pkg::DIVD_W-1:0]     dividend_i,
  input  logic [kssh_pkg::CNT_W-1:0]      divisor_i,
  output logic                            busy_o,
  output logic [kssh_pkg::DIVD_W-1:0]     quot_o
);
  import kssh_pkg::*;

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIVD_W-1:0]    q_q, q_d;
  logic [CNT_W-1:0]     r_q, r_d;
  logic [CNT_W-1:0]     d_q, d_d;
  logic [CNT_W:0]       r_sh;
  logic [CNT_W+1:0]     trial;

  assign r_sh  = {r_q, q_q[DIVD_W-1]};
  assign trial = {1'b0, r_sh} - {2'b00, d_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    q_d    = q_q;
    r_d    = r_q;
    d_d    = d_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIVD_W - 1);
      q_d    = dividend_i;
      r_d    = '0;
      d_d    = divisor_i;
    end else if (busy_q) begin
      if (trial[CNT_W+1]) begin
        r_d = r_sh[CNT_W-1:0];
        q_d = {q_q[DIVD_W-2:0], 1'b0};
      end else begin
        r_d = trial[CNT_W-1:0];
        q_d = {q_q[DIVD_W-2:0], 1'b1};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    d_q <= d_d;
  end

  assign busy_o = busy_q;
  assign quot_o = q_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("divider not busy after start");

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (r_q < d_q))
    else $error("remainder not below divisor");

  a_busy_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (cnt_q != '0)) |=> busy_q)
    else $error("divider stopped early");

endmodule

// ===== hdl/kernel_smoothed_score_hessian_top.sv =====
// Kernel-smoothed score Hessian accumulator. Each observation (outcome, two Q16.16
// regressors) adds one Gaussian-derivative kernel term to a 64-bit sum (at most
// MAX_ITEMS terms); the beat marked last_item is added first if the count allows,
// then the mean over the item count is delivered, clipped to signed 32 bits with
// the saturated flag, and sum and count are cleared. All six wide products of an
// observation share a single 33x33 multiplier, and the five with a 42-bit operand
// take two partial products each; in_ready stays low until the observation is
// accumulated. A last beat then runs the 63-step restoring divider.
// The kernel table is a constant ROM, so no start-up pass is needed after reset.
// Write beta and inv_bandwidth only while the block is idle.
module kernel_smoothed_score_hessian_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  kssh_pkg::in_item_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output kssh_pkg::out_item_t              out_data_o,
  input  logic                             cfg_we_i,
  input  logic [kssh_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [kssh_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import kssh_pkg::*;

  localparam kern_tab_t KERN_TAB = build_kern_tab();

  state_e state_q, state_d;

  logic [CFG_W-1:0]  beta_q, inv_q;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [K_W-1:0]    k_q, k_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_data_q, out_data_d;

  logic [31:0]       x1_q, x1_d, x2_q, x2_d;
  logic              y_q, y_d, last_q, last_d;
  logic [M_W-1:0]    m_q, m_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic              big_q, big_d, sneg_q, sneg_d, dneg_q, dneg_d;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        p;

  logic              in_acc, out_free, div_start, div_busy;
  logic [DIVD_W-1:0] div_quot;
  logic [SUM_W-1:0]  sum_abs;
  logic [CNT_W-1:0]  div_cnt;
  logic [31:0]       ax2, bop;
  logic [S_W-1:0]    s_val, s_mag;
  logic              in_range, q_sat;
  logic [TAB_AW-1:0] tab_idx;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign div_start  = (state_q == S_DSTART);
  assign p          = prod;

  assign ax2     = x2_q[31] ? (~x2_q + 32'd1) : x2_q;
  assign bop     = (k_q < K_FIRST_X2) ? inv_q : ax2;
  assign s_val   = {{(S_W-32){x1_q[31]}}, x1_q} + p[S_W+15:16];
  assign s_mag   = s_val[S_W-1] ? (~s_val + S_W'(1)) : s_val;
  assign in_range = !big_q && (acc_q[ACC_W-1:U_Q_W] == '0);
  assign tab_idx = acc_q[U_Q_W-1 -: TAB_AW];
  assign sum_abs = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
  assign div_cnt = (cnt_q == '0) ? CNT_W'(1) : cnt_q;

  always_comb begin
    unique case (state_q)
      S_BETA: begin
        mul_a = {x2_q[31], x2_q};
        mul_b = {beta_q[31], beta_q};
      end
      S_MLO: begin
        mul_a = {1'b0, m_q[31:0]};
        mul_b = {1'b0, bop};
      end
      S_MHI: begin
        mul_a = {{(MUL_W-M_HI_W){1'b0}}, m_q[M_W-1:32]};
        mul_b = {1'b0, bop};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  kssh_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  kssh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_abs[DIVD_W-1:0]),
    .divisor_i  (div_cnt),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cnt_q < CNT_W'(MAX_ITEMS)) begin
            state_d = S_BETA;
          end else if (in_data_i.last_item) begin
            state_d = S_DSTART;
          end
        end
      end
      S_BETA:   state_d = S_SUM;
      S_SUM:    state_d = S_MLO;
      S_MLO:    state_d = S_MHI;
      S_MHI:    state_d = S_MADD;
      S_MADD:   state_d = (k_q == K_U_PRODUCT) ? S_TAB : S_SAT;
      S_TAB:    state_d = S_MLO;
      S_SAT:    state_d = (k_q == MUL_STEPS) ? S_ACC : S_MLO;
      S_ACC:    state_d = last_q ? S_DSTART : S_IDLE;
      S_DSTART: state_d = S_DRUN;
      S_DRUN: begin
        if (!div_busy) begin
          state_d = S_DOUT;
        end
      end
      S_DOUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    x1_d        = x1_q;
    x2_d        = x2_q;
    y_d         = y_q;
    last_d      = last_q;
    m_d         = m_q;
    acc_d       = acc_q;
    big_d       = big_q;
    sneg_d      = sneg_q;
    dneg_d      = dneg_q;
    k_d         = k_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    out_data_d  = out_data_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    q_sat       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          x1_d   = in_data_i.first_regressor;
          x2_d   = in_data_i.second_regressor;
          y_d    = in_data_i.outcome;
          last_d = in_data_i.last_item;
        end
      end
      S_SUM: begin
        m_d    = M_W'(s_mag[U_Q_W-1:0]);
        big_d  = (s_mag[S_W-1:U_Q_W] != '0);
        sneg_d = s_val[S_W-1];
        k_d    = K_U_PRODUCT;
      end
      S_MHI: begin
        acc_d = ACC_W'(p[63:0]);
      end
      S_MADD: begin
        acc_d = acc_q + {p[M_W-1:0], 32'd0};
      end
      S_TAB: begin
        m_d = in_range ? M_W'(KERN_TAB[tab_idx]) : '0;
        k_d = k_q + K_W'(1);
      end
      S_SAT: begin
        m_d = (acc_q[ACC_W-1:M_W+16] != '0) ? '1 : acc_q[M_W+15:16];
        if (k_q != MUL_STEPS) begin
          k_d = k_q + K_W'(1);
        end
      end
      S_ACC: begin
        if (y_q == sneg_q) begin
          sum_d = sum_q + SUM_W'(m_q);
        end else begin
          sum_d = sum_q - SUM_W'(m_q);
        end
        cnt_d = cnt_q + CNT_W'(1);
      end
      S_DSTART: begin
        dneg_d = sum_q[SUM_W-1];
        sum_d  = '0;
        cnt_d  = '0;
      end
      S_DOUT: begin
        if (dneg_q) begin
          q_sat = (div_quot[DIVD_W-1:32] != '0) || (div_quot[31] && (div_quot[30:0] != '0));
          out_data_d.mean_value = q_sat ? OUT_MIN : (~div_quot[31:0] + 32'd1);
        end else begin
          q_sat = (div_quot[DIVD_W-1:31] != '0);
          out_data_d.mean_value = q_sat ? OUT_MAX : div_quot[31:0];
        end
        out_data_d.saturated = q_sat;
        if (out_free) begin
          out_valid_d = 1'b1;
        end else begin
          out_data_d = out_data_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      beta_q      <= BETA_RESET;
      inv_q       <= INV_BW_RESET;
      sum_q       <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_BETA:   beta_q <= cfg_wdata_i;
          REG_INV_BW: inv_q  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q       <= x1_d;
    x2_q       <= x2_d;
    y_q        <= y_d;
    last_q     <= last_d;
    m_q        <= m_d;
    acc_q      <= acc_d;
    big_q      <= big_d;
    sneg_q     <= sneg_d;
    dneg_q     <= dneg_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ITEMS))
    else $error("item count beyond limit");

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ((cnt_q < CNT_W'(MAX_ITEMS)) || in_data_i.last_item)) |=> !in_ready_o)
    else $error("ready while an observation is in flight");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DOUT) && out_valid_q && !out_ready_i) |=> (state_q == S_DOUT))
    else $error("result overwritten before it was taken");

endmodule
